// ===== hdl/bctf_pkg.sv =====
package bctf_pkg;

    // Channel count and buffer size of one half of the data store.
    localparam int CHANNELS     = 4;
    localparam int BUFFER_BYTES = 32;

    // Derived widths of the data store.
    localparam int BYTE_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int ADDR_W = $clog2(2 * BUFFER_BYTES);

    // Queue sizing shared by the input and result queues.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Pattern constants.
    localparam logic [7:0]  CHAN_MASK       = 8'((1 << CHANNELS) - 1);
    localparam logic [7:0]  LED_ALL_ON      = 8'hff;
    localparam logic [7:0]  LED_ALL_OFF     = 8'h00;
    localparam logic [3:0]  RUN_TICKS       = 4'd3;
    localparam logic [3:0]  CHAN_CNT        = 4'(CHANNELS);
    localparam logic [15:0] TICK_PERIOD_RST = 16'd1000;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REG_TICK_PERIOD    = 2'd0,
        REG_PATTERN_FIRST  = 2'd1,
        REG_PATTERN_SECOND = 2'd2,
        REG_PATTERN_THIRD  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_SESS_START = 3'd0,
        PH_SESS_SYNC  = 3'd1,
        PH_PATTERN    = 3'd2,
        PH_BEAM_START = 3'd3,
        PH_BEAM_SYNC  = 3'd4,
        PH_DATA       = 3'd5
    } t_phase;

    // One classified input item as it waits between front and back.
    typedef struct packed {
        logic       is_write;
        logic [4:0] write_index;
        logic [7:0] write_data;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [7:0]  led_pattern;
        logic [15:0] next_period;
        logic        buffer_swapped;
        logic [2:0]  phase_code;
    } t_result;

endpackage

// ===== hdl/bctf_front.sv =====
module bctf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_command,
    input  logic [4:0]          i_write_index,
    input  logic [7:0]          i_write_data,
    output logic                o_full,
    output logic                o_head_valid,
    output bctf_pkg::t_item     o_head,
    input  logic                i_head_pop
);

    bctf_pkg::t_item                 r_slot [bctf_pkg::QDEPTH];
    logic [bctf_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [bctf_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [bctf_pkg::QCNT_W-1:0]     r_count;
    logic                            accept;
    logic                            drain;
    bctf_pkg::t_item                 item_in;

    assign o_full       = (r_count == bctf_pkg::QCNT_W'(bctf_pkg::QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];
    assign accept       = i_push && !o_full;
    assign drain        = i_head_pop && o_head_valid;

    // Classify the item: writes and ticks take different paths in the back.
    always_comb begin
        item_in.is_write    = (bctf_pkg::t_cmd'(i_command) == bctf_pkg::CMD_WRITE);
        item_in.write_index = i_write_index;
        item_in.write_data  = i_write_data;
    end

    // Item storage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr_ptr] <= item_in;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= (r_wr_ptr == bctf_pkg::QPTR_W'(bctf_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (drain) begin
                r_rd_ptr <= (r_rd_ptr == bctf_pkg::QPTR_W'(bctf_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (accept && !drain) begin
                r_count <= r_count + 1'b1;
            end else if (drain && !accept) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/bctf_back.sv =====
module bctf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_head_valid,
    input  bctf_pkg::t_item     i_head,
    output logic                o_head_pop,
    input  logic                i_out_ready,
    output logic                o_res_valid,
    output bctf_pkg::t_result   o_res
);

    // Configuration registers.
    logic [15:0] r_tick_period;
    logic [7:0]  r_pattern_first;
    logic [7:0]  r_pattern_second;
    logic [7:0]  r_pattern_third;

    // Framer state.
    bctf_pkg::t_phase               r_phase, n_phase;
    logic [3:0]                     r_count, n_count;
    logic [2:0]                     r_bit_pos, n_bit_pos;
    logic [bctf_pkg::BYTE_W-1:0]    r_byte_pos, n_byte_pos;
    logic                           r_half, n_half;
    logic [15:0]                    r_period, n_period;

    // Data store with one valid bit per entry; an entry never written reads zero.
    logic [7:0]                         r_mem [2 * bctf_pkg::BUFFER_BYTES];
    logic [2 * bctf_pkg::BUFFER_BYTES-1:0] r_valid;
    logic [7:0]                         r_rd_data;
    logic                               r_rd_valid;
    logic [bctf_pkg::ADDR_W-1:0]        rd_addr;
    logic [bctf_pkg::ADDR_W-1:0]        wr_addr;
    logic                               wr_in_range;

    logic        take_item;
    logic        do_tick;
    logic        do_write;
    logic [3:0]  cnt_inc;
    logic [15:0] half_period;
    logic        byte_last;
    logic [7:0]  cur_byte;
    logic        cur_bit;
    logic [7:0]  led;
    logic        swapped;

    function automatic logic [bctf_pkg::ADDR_W-1:0] buf_addr(
        input logic                        half,
        input logic [bctf_pkg::BYTE_W-1:0] pos
    );
        logic [bctf_pkg::ADDR_W-1:0] base;
        base = half ? bctf_pkg::ADDR_W'(bctf_pkg::BUFFER_BYTES) : '0;
        return base + bctf_pkg::ADDR_W'(pos);
    endfunction

    // Handshake with the front queue and the result queue.
    assign take_item   = i_head_valid && (i_head.is_write || i_out_ready);
    assign do_tick     = take_item && !i_head.is_write;
    assign do_write    = take_item && i_head.is_write;
    assign o_head_pop  = take_item;
    assign o_res_valid = do_tick;

    assign cnt_inc     = r_count + 4'd1;
    assign half_period = r_tick_period >> 1;
    assign byte_last   = (r_byte_pos == bctf_pkg::BYTE_W'(bctf_pkg::BUFFER_BYTES - 1));
    assign cur_byte    = r_rd_valid ? r_rd_data : 8'h00;
    assign cur_bit     = cur_byte[r_bit_pos];

    // Writes go to the idle half; positions beyond the buffer are dropped.
    assign wr_in_range = ({4'b0000, i_head.write_index} < 9'(bctf_pkg::BUFFER_BYTES));
    assign wr_addr     = buf_addr(!r_half, bctf_pkg::BYTE_W'(i_head.write_index));

    // The store is read at the position the next tick will use.
    assign rd_addr = i_rst_n ? buf_addr(n_half, n_byte_pos) : '0;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period    <= bctf_pkg::TICK_PERIOD_RST;
            r_pattern_first  <= 8'h00;
            r_pattern_second <= 8'h00;
            r_pattern_third  <= 8'h00;
        end else if (i_cfg_we) begin
            unique case (bctf_pkg::t_reg_idx'(i_cfg_index))
                bctf_pkg::REG_TICK_PERIOD:    r_tick_period    <= i_cfg_data;
                bctf_pkg::REG_PATTERN_FIRST:  r_pattern_first  <= i_cfg_data[7:0];
                bctf_pkg::REG_PATTERN_SECOND: r_pattern_second <= i_cfg_data[7:0];
                bctf_pkg::REG_PATTERN_THIRD:  r_pattern_third  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Next state of the framer for a tick.
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_bit_pos  = r_bit_pos;
        n_byte_pos = r_byte_pos;
        n_half     = r_half;
        n_period   = r_period;
        if (do_tick) begin
            unique case (r_phase)
                bctf_pkg::PH_SESS_SYNC: begin
                    n_period = half_period;
                    n_phase  = bctf_pkg::PH_PATTERN;
                    n_count  = 4'd0;
                end
                bctf_pkg::PH_PATTERN: begin
                    n_period = r_tick_period;
                    n_count  = cnt_inc;
                    if (cnt_inc >= bctf_pkg::RUN_TICKS) begin
                        n_phase    = bctf_pkg::PH_BEAM_START;
                        n_count    = 4'd0;
                        n_bit_pos  = 3'd0;
                        n_byte_pos = '0;
                    end
                end
                bctf_pkg::PH_BEAM_START: begin
                    n_period = r_tick_period;
                    n_count  = cnt_inc;
                    if (cnt_inc >= bctf_pkg::RUN_TICKS) begin
                        n_phase  = bctf_pkg::PH_BEAM_SYNC;
                        n_count  = 4'd0;
                        n_period = half_period;
                    end
                end
                bctf_pkg::PH_BEAM_SYNC: begin
                    n_period = half_period;
                    n_phase  = bctf_pkg::PH_DATA;
                    n_count  = 4'd0;
                end
                bctf_pkg::PH_DATA: begin
                    n_count   = cnt_inc;
                    n_bit_pos = r_bit_pos + 3'd1;
                    if (r_bit_pos == 3'd7 && byte_last) begin
                        // End of buffer wins over the sub-session restart.
                        n_byte_pos = '0;
                        n_phase    = bctf_pkg::PH_SESS_START;
                        n_count    = 4'd0;
                        n_half     = !r_half;
                    end else begin
                        if (r_bit_pos == 3'd7) begin
                            n_byte_pos = r_byte_pos + 1'b1;
                        end
                        if (cnt_inc >= bctf_pkg::CHAN_CNT) begin
                            n_phase = bctf_pkg::PH_BEAM_START;
                            n_count = 4'd0;
                        end
                    end
                end
                default: begin
                    // Session start, and any stray code behaves the same way.
                    n_period = r_tick_period;
                    n_count  = cnt_inc;
                    n_phase  = bctf_pkg::PH_SESS_START;
                    if (cnt_inc >= bctf_pkg::RUN_TICKS) begin
                        n_phase  = bctf_pkg::PH_SESS_SYNC;
                        n_count  = 4'd0;
                        n_period = half_period;
                    end
                end
            endcase
        end
    end

    // LED pattern and swap flag of the current tick.
    always_comb begin
        led     = bctf_pkg::LED_ALL_OFF;
        swapped = 1'b0;
        unique case (r_phase) inside
            bctf_pkg::PH_SESS_SYNC, bctf_pkg::PH_BEAM_SYNC: begin
                led = bctf_pkg::LED_ALL_OFF;
            end
            bctf_pkg::PH_PATTERN: begin
                if (r_count == 4'd0) begin
                    led = r_pattern_first & bctf_pkg::CHAN_MASK;
                end else if (r_count == 4'd1) begin
                    led = r_pattern_second & bctf_pkg::CHAN_MASK;
                end else begin
                    led = r_pattern_third & bctf_pkg::CHAN_MASK;
                end
            end
            bctf_pkg::PH_DATA: begin
                if (r_count < bctf_pkg::CHAN_CNT) begin
                    led = 8'(cur_bit) << r_count;
                end
                swapped = (r_bit_pos == 3'd7) && byte_last;
            end
            default: begin
                led = bctf_pkg::LED_ALL_ON;
            end
        endcase
    end

    // Result item.
    always_comb begin
        o_res.led_pattern    = led;
        o_res.next_period    = n_period;
        o_res.buffer_swapped = swapped;
        o_res.phase_code     = n_phase;
    end

    // State registers and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= bctf_pkg::PH_SESS_START;
            r_count    <= 4'd0;
            r_bit_pos  <= 3'd0;
            r_byte_pos <= '0;
            r_half     <= 1'b0;
            r_period   <= 16'd0;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_bit_pos  <= n_bit_pos;
            r_byte_pos <= n_byte_pos;
            r_half     <= n_half;
            r_period   <= n_period;
            r_rd_valid <= r_valid[rd_addr];
            if (do_write && wr_in_range) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // Data store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (do_write && wr_in_range) begin
            r_mem[wr_addr] <= i_head.write_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

// ===== hdl/bctf_out_queue.sv =====
module bctf_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bctf_pkg::t_result   i_item,
    output logic                o_ready,
    output logic                o_empty,
    output bctf_pkg::t_result   o_head,
    input  logic                i_pop
);

    bctf_pkg::t_result               r_slot [bctf_pkg::QDEPTH];
    logic [bctf_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [bctf_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [bctf_pkg::QCNT_W-1:0]     r_count;
    logic                            drain;

    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign drain   = i_pop && !o_empty;
    // A full queue still takes an item in the cycle its head leaves.
    assign o_ready = (r_count != bctf_pkg::QCNT_W'(bctf_pkg::QDEPTH)) || drain;

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == bctf_pkg::QPTR_W'(bctf_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (drain) begin
                r_rd_ptr <= (r_rd_ptr == bctf_pkg::QPTR_W'(bctf_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !drain) begin
                r_count <= r_count + 1'b1;
            end else if (drain && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/beam_curtain_tx_framer_unit.sv =====
// Channel   Direction  Handshake          Payload
// input     in         push / full        i_command, i_write_index, i_write_data
// result    out        empty / pop        o_led_pattern, o_next_period,
//                                         o_buffer_swapped, o_phase_code
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One item per cycle is taken and carried out while the result queue has room;
// a tick passes through the input queue, then the framer into the result queue.
// The rate is set by the framer state update, one item per cycle.
// Reset is synchronous and active low; the data store reads zero until written.
// A stalled result side fills the result queue and then backs up the input queue.
module beam_curtain_tx_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [4:0]  i_write_index,
    input  logic [7:0]  i_write_data,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_led_pattern,
    output logic [15:0] o_next_period,
    output logic        o_buffer_swapped,
    output logic [2:0]  o_phase_code,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    bctf_pkg::t_item   head;
    logic              head_valid;
    logic              head_pop;
    bctf_pkg::t_result res;
    logic              res_valid;
    logic              out_ready;
    bctf_pkg::t_result out_head;

    // Front: accepts and classifies items.
    bctf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_command     (i_command),
        .i_write_index (i_write_index),
        .i_write_data  (i_write_data),
        .o_full        (full),
        .o_head_valid  (head_valid),
        .o_head        (head),
        .i_head_pop    (head_pop)
    );

    // Back: framer state machine and data store.
    bctf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .i_out_ready  (out_ready),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Result queue toward the consumer.
    bctf_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res),
        .o_ready (out_ready),
        .o_empty (empty),
        .o_head  (out_head),
        .i_pop   (pop)
    );

    assign o_led_pattern    = out_head.led_pattern;
    assign o_next_period    = out_head.next_period;
    assign o_buffer_swapped = out_head.buffer_swapped;
    assign o_phase_code     = out_head.phase_code;

endmodule

// ===== hdl/bctf_checker.sv =====
module bctf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_led_pattern,
    input logic [15:0] o_next_period,
    input logic        o_buffer_swapped,
    input logic [2:0]  o_phase_code
);

    // The result queue is empty right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A waiting result stays until it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_led_pattern) && $stable(o_next_period)))
        else $error("waiting result changed before it was taken");

    // A buffer swap always restarts the session.
    a_swap_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_buffer_swapped) |-> (o_phase_code == bctf_pkg::PH_SESS_START))
        else $error("buffer swap without session restart");

    // For results whose phase code is the data phase, at most one channel is driven.
    a_data_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_phase_code == bctf_pkg::PH_DATA) |-> $onehot0(o_led_pattern))
        else $error("more than one channel driven in a data tick");

endmodule

bind beam_curtain_tx_framer_unit bctf_checker u_bctf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_led_pattern    (o_led_pattern),
    .o_next_period    (o_next_period),
    .o_buffer_swapped (o_buffer_swapped),
    .o_phase_code     (o_phase_code)
);

// ===== test/framer_tick_checker.sv =====
`timescale 1ns / 1ps

// Watches the item and result queues of the framer, predicts every tick
// result from its own copy of the framer state and compares field by field.
module framer_tick_checker
    import bctf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        i_command,
    input  logic [4:0]  i_write_index,
    input  logic [7:0]  i_write_data,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  o_led_pattern,
    input  logic [15:0] o_next_period,
    input  logic        o_buffer_swapped,
    input  logic [2:0]  o_phase_code,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_ticks,
    output int          o_writes,
    output int          o_swaps
);

    // Register copies.
    logic [15:0] tick_period;
    logic [7:0]  pattern_first;
    logic [7:0]  pattern_second;
    logic [7:0]  pattern_third;

    // Framer state copies.
    t_phase      ph;
    logic [3:0]  run_cnt;
    logic [2:0]  bit_pos;
    int          byte_pos;
    logic        send_half;
    logic [15:0] cur_period;
    logic [7:0]  store [2 * BUFFER_BYTES];

    // Results predicted for ticks that have been accepted but not yet popped.
    t_result     expected_ticks [$];
    int          mismatches;
    int          ticks;
    int          writes;
    int          swaps;

    // Advances the framer by one timer tick and returns the result it emits.
    task automatic advance_framer(output t_result r);
        logic [7:0] led;
        logic       bit_val;
        logic       swapped;
        led     = LED_ALL_OFF;
        swapped = 1'b0;
        case (ph)
            PH_SESS_SYNC, PH_BEAM_SYNC: begin
                // Sync ticks are dark and run at half period.
                cur_period = tick_period >> 1;
                if (ph == PH_SESS_SYNC) begin
                    ph = PH_PATTERN;
                end else begin
                    ph = PH_DATA;
                end
                run_cnt = '0;
            end
            PH_PATTERN: begin
                cur_period = tick_period;
                if (run_cnt == 4'd0) begin
                    led = pattern_first;
                end else if (run_cnt == 4'd1) begin
                    led = pattern_second;
                end else begin
                    led = pattern_third;
                end
                led     = led & CHAN_MASK;
                run_cnt = run_cnt + 4'd1;
                if (run_cnt >= RUN_TICKS) begin
                    ph       = PH_BEAM_START;
                    run_cnt  = '0;
                    bit_pos  = '0;
                    byte_pos = 0;
                end
            end
            PH_DATA: begin
                // One buffer bit, placed on the channel of this data tick.
                bit_val = store[(send_half ? BUFFER_BYTES : 0) + byte_pos][bit_pos];
                if (run_cnt < CHAN_CNT) begin
                    led = 8'(bit_val) << run_cnt;
                end
                run_cnt = run_cnt + 4'd1;
                bit_pos = bit_pos + 3'd1;
                if (bit_pos == 3'd0) begin
                    byte_pos++;
                    // The end of the buffer wins over the sub-session restart.
                    if (byte_pos >= BUFFER_BYTES) begin
                        byte_pos  = 0;
                        ph        = PH_SESS_START;
                        run_cnt   = '0;
                        send_half = ~send_half;
                        swapped   = 1'b1;
                    end
                end
                if (!swapped && run_cnt >= CHAN_CNT) begin
                    ph      = PH_BEAM_START;
                    run_cnt = '0;
                end
            end
            default: begin
                // Start ticks of a session or of a sub-session.
                led        = LED_ALL_ON;
                cur_period = tick_period;
                run_cnt    = run_cnt + 4'd1;
                if (run_cnt >= RUN_TICKS) begin
                    if (ph == PH_BEAM_START) begin
                        ph = PH_BEAM_SYNC;
                    end else begin
                        ph = PH_SESS_SYNC;
                    end
                    run_cnt    = '0;
                    cur_period = tick_period >> 1;
                end
            end
        endcase
        r.led_pattern    = led;
        r.next_period    = cur_period;
        r.buffer_swapped = swapped;
        r.phase_code     = ph;
    endtask

    // Track configuration, accepted items and accepted results.
    always @(posedge i_clk) begin : track
        t_result want;
        if (!i_rst_n) begin
            tick_period    = TICK_PERIOD_RST;
            pattern_first  = '0;
            pattern_second = '0;
            pattern_third  = '0;
            ph             = PH_SESS_START;
            run_cnt        = '0;
            bit_pos        = '0;
            byte_pos       = 0;
            send_half      = 1'b0;
            cur_period     = '0;
            for (int k = 0; k < 2 * BUFFER_BYTES; k++) begin
                store[k] = '0;
            end
            expected_ticks.delete();
            mismatches = 0;
            ticks      = 0;
            writes     = 0;
            swaps      = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TICK_PERIOD:    tick_period    = i_cfg_data;
                    REG_PATTERN_FIRST:  pattern_first  = i_cfg_data[7:0];
                    REG_PATTERN_SECOND: pattern_second = i_cfg_data[7:0];
                    REG_PATTERN_THIRD:  pattern_third  = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // Compare the popped result with the oldest prediction.
            if (pop && !empty) begin
                if (expected_ticks.size() == 0) begin
                    $error("result popped with no tick waiting");
                    mismatches++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (o_led_pattern !== want.led_pattern) begin
                        $error("led_pattern: expected %0h, got %0h",
                               want.led_pattern, o_led_pattern);
                        mismatches++;
                    end
                    if (o_next_period !== want.next_period) begin
                        $error("next_period: expected %0d, got %0d",
                               want.next_period, o_next_period);
                        mismatches++;
                    end
                    if (o_buffer_swapped !== want.buffer_swapped) begin
                        $error("buffer_swapped: expected %0d, got %0d",
                               want.buffer_swapped, o_buffer_swapped);
                        mismatches++;
                    end
                    if (o_phase_code !== want.phase_code) begin
                        $error("phase_code: expected %0d, got %0d",
                               want.phase_code, o_phase_code);
                        mismatches++;
                    end
                end
            end

            // Writes go to the idle half; ticks produce one result each.
            if (push && !full) begin
                if (i_command == CMD_WRITE) begin
                    if (int'(i_write_index) < BUFFER_BYTES) begin
                        store[(send_half ? 0 : BUFFER_BYTES) + int'(i_write_index)] =
                            i_write_data;
                    end
                    writes++;
                end else begin
                    advance_framer(want);
                    expected_ticks.push_back(want);
                    ticks++;
                    if (want.buffer_swapped) begin
                        swaps++;
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_ticks.size();
        o_ticks      <= ticks;
        o_writes     <= writes;
        o_swaps      <= swaps;
    end

endmodule

// ===== test/tb_beam_curtain_tx_framer_unit.sv =====
`timescale 1ns / 1ps

module tb_beam_curtain_tx_framer_unit;
    import bctf_pkg::*;

    localparam int PHASE_ITEMS = 315;
    localparam int SETTLE      = 6;
    localparam int QUIET_LIMIT = 400;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic        i_command     = 1'b0;
    logic [4:0]  i_write_index = '0;
    logic [7:0]  i_write_data  = '0;
    logic        empty;
    logic        pop           = 1'b0;
    logic [7:0]  o_led_pattern;
    logic [15:0] o_next_period;
    logic        o_buffer_swapped;
    logic [2:0]  o_phase_code;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;

    logic [15:0] pop_pattern   = 16'hffff;
    logic [3:0]  pop_slot      = '0;

    int          mismatches;
    int          pending;
    int          ticks;
    int          writes;
    int          swaps;

    beam_curtain_tx_framer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_command        (i_command),
        .i_write_index    (i_write_index),
        .i_write_data     (i_write_data),
        .empty            (empty),
        .pop              (pop),
        .o_led_pattern    (o_led_pattern),
        .o_next_period    (o_next_period),
        .o_buffer_swapped (o_buffer_swapped),
        .o_phase_code     (o_phase_code),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    framer_tick_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_command        (i_command),
        .i_write_index    (i_write_index),
        .i_write_data     (i_write_data),
        .empty            (empty),
        .pop              (pop),
        .o_led_pattern    (o_led_pattern),
        .o_next_period    (o_next_period),
        .o_buffer_swapped (o_buffer_swapped),
        .o_phase_code     (o_phase_code),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_ticks          (ticks),
        .o_writes         (writes),
        .o_swaps          (swaps)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver pops on a rotating stall pattern set per phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_slot <= '0;
        end else begin
            pop      <= pop_pattern[pop_slot];
            pop_slot <= pop_slot + 4'd1;
        end
    end

    // Offers one item and holds it until the queue takes it.
    task automatic send_item(input t_cmd cmd, input logic [4:0] idx, input logic [7:0] data);
        push          <= 1'b1;
        i_command     <= cmd;
        i_write_index <= idx;
        i_write_data  <= data;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_sender(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stops sending until every predicted result has been popped, then lets
    // the pipeline settle with the sender idle.
    task automatic drain_results();
        push <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes all four registers back to back.
    task automatic write_settings(input logic [15:0] period, input logic [7:0] pa,
                                  input logic [7:0] pb, input logic [7:0] pc);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_TICK_PERIOD;
        i_cfg_data  <= period;
        @(posedge i_clk);
        i_cfg_index <= REG_PATTERN_FIRST;
        i_cfg_data  <= {8'($urandom), pa};
        @(posedge i_clk);
        i_cfg_index <= REG_PATTERN_SECOND;
        i_cfg_data  <= {8'($urandom), pb};
        @(posedge i_clk);
        i_cfg_index <= REG_PATTERN_THIRD;
        i_cfg_data  <= {8'($urandom), pc};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Ends the run if nothing is accepted on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_beam_curtain_tx_framer_unit failed");
        $finish;
    end

    // Stimulus: directed opening, then random phases under several settings.
    initial begin : stimulus
        logic [15:0] period;
        logic [7:0]  pa;
        logic [7:0]  pb;
        logic [7:0]  pc;
        logic [7:0]  data;
        logic        gaps_on;
        int          burst_left;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset settings: byte extremes into the idle
        // half, then a session opening and one sub-session and a bit more.
        send_item(CMD_WRITE, 5'd0, 8'hff);
        send_item(CMD_WRITE, 5'd31, 8'h80);
        send_item(CMD_WRITE, 5'd10, 8'h55);
        send_item(CMD_WRITE, 5'd1, 8'h00);
        repeat (19) send_item(CMD_TICK, 5'd31, 8'hff);

        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: begin
                    period = 16'd1;
                    pa = 8'h00; pb = 8'h00; pc = 8'h00;
                end
                1: begin
                    period = 16'hffff;
                    pa = 8'hff; pb = 8'hff; pc = 8'hff;
                end
                2: begin
                    period = 16'd2;
                    pa = 8'($urandom); pb = 8'($urandom); pc = 8'($urandom);
                end
                4: begin
                    period = 16'd3;
                    pa = 8'($urandom); pb = 8'($urandom); pc = 8'($urandom);
                end
                default: begin
                    period = 16'($urandom_range(1, 65535));
                    pa = 8'($urandom); pb = 8'($urandom); pc = 8'($urandom);
                end
            endcase
            write_settings(period, pa, pb, pc);

            // Receiver: no stalls, random stalls or heavy stalls.
            case (p % 3)
                0: pop_pattern <= 16'hffff;
                1: pop_pattern <= 16'($urandom) | 16'h0001;
                default: pop_pattern <= 16'($urandom & $urandom & $urandom) | 16'h0001;
            endcase
            gaps_on    = (p != 1) && (p != 4);
            burst_left = $urandom_range(1, 24);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                if (burst_left == 0) begin
                    if (gaps_on) begin
                        idle_sender($urandom_range(1, 6));
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if ($urandom_range(0, 99) < 20) begin
                    case ($urandom_range(0, 3))
                        0: data = 8'h00;
                        1: data = 8'hff;
                        default: data = 8'($urandom);
                    endcase
                    send_item(CMD_WRITE, 5'($urandom), data);
                end else begin
                    send_item(CMD_TICK, 5'($urandom), 8'($urandom));
                end
            end
        end
        drain_results();

        $display("Run covered %0d timer ticks and %0d buffer writes over seven settings,",
                 ticks, writes);
        $display("with %0d buffer swaps and stalls on both queues.", swaps);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_beam_curtain_tx_framer_unit passed");
        end else begin
            $display("tb_beam_curtain_tx_framer_unit failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bctf_pkg.sv
hdl/bctf_front.sv
hdl/bctf_back.sv
hdl/bctf_out_queue.sv
hdl/beam_curtain_tx_framer_unit.sv
hdl/bctf_checker.sv
test/framer_tick_checker.sv
test/tb_beam_curtain_tx_framer_unit.sv
